>>> src/lap3_pkg.sv
// package for the 3x3 laplacian rgb filter: field widths, register codes,
// reset values and the per-channel kernel function
// no dependencies

package lap3_pkg;

    localparam int CH_W       = 8;
    localparam int NUM_CH     = 3;
    localparam int PIX_W      = CH_W * NUM_CH;
    localparam int FW_W       = 11;
    localparam int FH_W       = 13;
    localparam int ROW_W      = 14;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_KERNEL_MODE  = 2'd2;

    localparam logic [FW_W-1:0] RST_FRAME_WIDTH  = 11'd640;
    localparam logic [FH_W-1:0] RST_FRAME_HEIGHT = 13'd480;
    localparam logic            RST_KERNEL_MODE  = 1'b0;

    localparam logic KERNEL_FOUR  = 1'b0;
    localparam logic KERNEL_EIGHT = 1'b1;

    localparam logic [CH_W-1:0] CH_MAX = 8'd255;

    // red in the low byte, then green, then blue
    typedef logic [PIX_W-1:0] t_pixel;
    typedef logic [8:0][CH_W-1:0] t_chan_win;

    // one channel of the laplacian, clamped to 0..255
    function automatic logic [CH_W-1:0] lap_channel(input logic mode, input t_chan_win win);
        logic        [9:0]  edge_sum;
        logic        [9:0]  corner_sum;
        logic signed [12:0] cen;
        logic signed [12:0] sum;
        edge_sum   = 10'(win[1]) + 10'(win[3]) + 10'(win[5]) + 10'(win[7]);
        corner_sum = 10'(win[0]) + 10'(win[2]) + 10'(win[6]) + 10'(win[8]);
        cen        = $signed({5'b0, win[4]});
        if (mode == KERNEL_EIGHT) begin
            sum = (cen <<< 3) - $signed({3'b0, edge_sum}) - $signed({3'b0, corner_sum});
        end else begin
            sum = (cen <<< 2) - $signed({3'b0, edge_sum});
        end
        if (sum < 0) begin
            lap_channel = '0;
        end else if (sum > $signed({5'b0, CH_MAX})) begin
            lap_channel = CH_MAX;
        end else begin
            lap_channel = sum[CH_W-1:0];
        end
    endfunction

endpackage

>>> src/laplace_filter_3x3_rgb.sv
// top level of the 3x3 laplacian rgb filter: row memories, window and output register
// depends on lap3_pkg
//
// Usage: pixels enter in raster order on the s_axis channel, one per transfer,
// red/green/blue in tdata and the fill flag in tuser. After the last pixel of a
// frame, width + 1 fill transfers push out the remaining results. Results leave
// on m_axis; tlast marks the last pixel of the frame. Border rows and columns
// pass through unchanged, inner pixels get the kernel chosen by kernel_mode.
// Registers are written on the cfg channel (always ready); the user must write
// them only while the block idles; the block itself does not enforce this.
// Throughput: one pixel per cycle unless the receiver stalls, set by the read
// of the two row memories and the kernel between read stage and output
// register. A result passes the read stage, then the output register, after
// the transfer that completes its pixel, width + 1 positions later in the stream.
// Reset clears counters, window and valid flags and restores the register
// defaults; the row memories are not cleared and need no clearing pass.
// When the receiver stalls, the result holds in the output register and the
// read stage fills; s_axis_tready then drops until the result is taken.

module laplace_filter_3x3_rgb
    import lap3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write channel
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel input
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,  // red_in, green_in, blue_in
    input  logic                  s_axis_tuser,  // is_fill
    // filtered output
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,  // red_out, green_out, blue_out
    output logic                  m_axis_tlast   // frame_end
);

    localparam int ADDR_W = $clog2(MAX_WIDTH);
    localparam int WID_W  = $clog2(MAX_WIDTH + 1);

    logic [FW_W-1:0] r_frame_width;
    logic [FH_W-1:0] r_frame_height;
    logic            r_kernel_mode;

    logic [WID_W-1:0]  eff_w;
    logic [FH_W-1:0]   eff_h;
    logic [ROW_W-1:0]  row_h;
    logic [ADDR_W-1:0] last_addr;

    logic [ADDR_W-1:0] r_col;
    logic [ROW_W-1:0]  r_row;

    logic             in_picture;
    logic             accept;
    logic             load;
    t_pixel           px;
    logic             emit;
    logic             col_zero;
    logic             fend;
    logic             border;
    logic [WID_W-1:0] col_inc;
    logic             wrap;

    // row memories
    t_pixel mem_a [MAX_WIDTH];
    t_pixel mem_b [MAX_WIDTH];
    t_pixel r_rd_a;
    t_pixel r_rd_top;
    t_pixel r_rd_last;
    logic              r_wr_pend;
    logic [ADDR_W-1:0] r_wr_addr;
    logic              r_byp_top;
    logic              r_byp_last;
    t_pixel            r_byp_data;

    // read stage
    logic   r_s1_valid;
    logic   r_s1_emit;
    logic   r_s1_border;
    logic   r_s1_czero;
    logic   r_s1_fend;
    t_pixel r_s1_px;

    t_pixel top;
    t_pixel mid;
    t_pixel last_b;

    t_pixel r_win [9];
    t_pixel n_win [9];
    t_pixel conv_px;
    t_pixel result;

    logic out_free;
    logic s1_move;

    logic   r_out_valid;
    t_pixel r_out_data;
    logic   r_out_last;

    // configuration
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_frame_width  <= RST_FRAME_WIDTH;
            r_frame_height <= RST_FRAME_HEIGHT;
            r_kernel_mode  <= RST_KERNEL_MODE;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FRAME_WIDTH:  r_frame_width  <= i_cfg_data[FW_W-1:0];
                CFG_FRAME_HEIGHT: r_frame_height <= i_cfg_data[FH_W-1:0];
                CFG_KERNEL_MODE:  r_kernel_mode  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // effective frame size
    always_comb begin
        if (32'(r_frame_width) > 32'(MAX_WIDTH)) begin
            eff_w = WID_W'(MAX_WIDTH);
        end else if (r_frame_width < FW_W'(3)) begin
            eff_w = WID_W'(3);
        end else begin
            eff_w = WID_W'(r_frame_width);
        end
        eff_h = (r_frame_height < FH_W'(3)) ? FH_W'(3) : r_frame_height;
    end

    assign row_h     = ROW_W'(eff_h);
    assign last_addr = ADDR_W'(eff_w - WID_W'(1));

    // position decode for the incoming item
    assign in_picture = r_row < row_h;
    assign accept     = s_axis_tvalid && s_axis_tready;
    // a fill inside the picture is dropped
    assign load       = accept && !(in_picture && s_axis_tuser);
    assign px         = in_picture ? s_axis_tdata : '0;

    assign col_zero = r_col == '0;
    assign emit     = (r_row >= ROW_W'(2)) || ((r_row == ROW_W'(1)) && !col_zero);
    assign fend     = emit && col_zero && (r_row >= row_h + ROW_W'(1));
    assign col_inc  = WID_W'(r_col) + WID_W'(1);
    assign wrap     = col_inc >= eff_w;
    // output pixel sits on the frame border
    assign border   = col_zero || (r_row == ROW_W'(1)) || (r_row >= row_h)
                   || (r_col == ADDR_W'(1)) || (WID_W'(r_col) >= eff_w);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (load) begin
            if (fend) begin
                r_col <= '0;
                r_row <= '0;
            end else if (wrap) begin
                r_col <= '0;
                r_row <= r_row + ROW_W'(1);
            end else begin
                r_col <= col_inc[ADDR_W-1:0];
            end
        end
    end

    // row memory a: newest row
    always_ff @(posedge i_clk) begin
        if (load) begin
            mem_a[r_col] <= px;
            r_rd_a       <= mem_a[r_col];
        end
    end

    // row memory b: older row, written with the value just read from a
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_rd_top  <= mem_b[r_col];
            r_rd_last <= mem_b[last_addr];
        end
        if (r_wr_pend) begin
            mem_b[r_wr_addr] <= r_rd_a;
        end
    end

    // forward the write that lands on the same edge as a read
    always_ff @(posedge i_clk) begin
        if (load) begin
            r_wr_addr  <= r_col;
            r_byp_top  <= r_wr_pend && (r_wr_addr == r_col);
            r_byp_last <= r_wr_pend && (r_wr_addr == last_addr);
            r_byp_data <= r_rd_a;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_pend <= 1'b0;
        end else begin
            r_wr_pend <= load;
        end
    end

    // read stage
    assign out_free      = !r_out_valid || m_axis_tready;
    assign s1_move       = r_s1_valid && (out_free || !r_s1_emit);
    assign s_axis_tready = !r_s1_valid || s1_move;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (load) begin
            r_s1_valid <= 1'b1;
        end else if (s1_move) begin
            r_s1_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_s1_emit   <= emit;
            r_s1_border <= border;
            r_s1_czero  <= col_zero;
            r_s1_fend   <= fend;
            r_s1_px     <= px;
        end
    end

    assign top    = r_byp_top  ? r_byp_data : r_rd_top;
    assign last_b = r_byp_last ? r_byp_data : r_rd_last;
    assign mid    = r_rd_a;

    // window shift and kernel
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            n_win[i*3]     = r_win[i*3 + 1];
            n_win[i*3 + 1] = r_win[i*3 + 2];
        end
        n_win[2] = top;
        n_win[5] = mid;
        n_win[8] = r_s1_px;
    end

    always_comb begin
        t_chan_win cw;
        for (int ch = 0; ch < NUM_CH; ch++) begin
            for (int k = 0; k < 9; k++) begin
                cw[k] = n_win[k][ch*CH_W +: CH_W];
            end
            conv_px[ch*CH_W +: CH_W] = lap_channel(r_kernel_mode, cw);
        end
    end

    always_comb begin
        if (!r_s1_border) begin
            result = conv_px;
        end else if (r_s1_czero) begin
            result = last_b;
        end else begin
            result = n_win[4];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 9; k++) begin
                r_win[k] <= '0;
            end
        end else if (s1_move) begin
            r_win <= n_win;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_move && r_s1_emit) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_move && r_s1_emit) begin
            r_out_data <= result;
            r_out_last <= r_s1_fend;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;
    assign m_axis_tlast  = r_out_last;

endmodule

>>> src/lap3_checker.sv
// port-level checks for the 3x3 laplacian rgb filter, bound to the top level
// depends on lap3_pkg and laplace_filter_3x3_rgb

module lap3_checker
    import lap3_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tvalid,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,  // red_out, green_out, blue_out
    input logic             m_axis_tlast   // frame_end
);

    // a pending result stays until its transfer
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("output valid dropped before transfer");

    // a stalled result keeps its pixel and frame end flag
    a_out_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output data changed before transfer");

    // reset empties the output register
    a_rst_clear: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // a rise of output valid needs an input transfer that passed through the read stage and the output register
    a_out_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(m_axis_tvalid) |-> $past(s_axis_tvalid && s_axis_tready, 2))
        else $error("result appeared without a matching input transfer");

    // with the output register empty the input side never stalls
    a_no_false_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled while output register empty");

endmodule

bind laplace_filter_3x3_rgb lap3_checker u_lap3_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
);
